FILE: src/vna_pkg.sv
// vna_pkg: shared types and constants for the vector norm accumulator
// no dependencies; used by vna_isqrt and vector_norm_accumulator
package vna_pkg;

   localparam int ELEMENT_WIDTH_DEF = 32;
   localparam int ACC_WIDTH         = 64;

   // norm mode register codes
   typedef enum logic [1:0] {
      MODE_INF  = 2'd0,
      MODE_L2   = 2'd1,
      MODE_L2SQ = 2'd2,
      MODE_L1   = 2'd3
   } norm_mode_type;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_ACC  = 5'b00100,
      ST_SQRT = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   // status of the square root unit
   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_status_type;

endpackage

FILE: src/vna_isqrt.sv
// vna_isqrt: iterative floor square root of a 64-bit value, one root bit per cycle
// depends on vna_pkg
module vna_isqrt import vna_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [ACC_WIDTH-1:0]   radicand,
   output sqrt_status_type        status,
   output logic [ACC_WIDTH-1:0]   root
);

   localparam logic [ACC_WIDTH-1:0] TOP_BIT = {2'b01, {(ACC_WIDTH-2){1'b0}}};

   logic [ACC_WIDTH-1:0] rem_ff, rem_in;
   logic [ACC_WIDTH-1:0] root_ff, root_in;
   logic [ACC_WIDTH-1:0] bit_ff, bit_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [ACC_WIDTH-1:0] trial;

   // the one shared compare and subtract
   assign trial = root_ff + bit_ff;

   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = radicand;
         root_in = '0;
         bit_in  = TOP_BIT;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         // last digit when the trial bit reaches the lsb
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule

FILE: src/vector_norm_accumulator.sv
// vector_norm_accumulator: infinity, L1, L2 and squared L2 norm over a stream of elements
// depends on vna_pkg and vna_isqrt
//
//   channel  direction  signals                                  handshake
//   req      in         req_element_value, req_is_last_element   req_valid / req_ready
//   rsp      out        rsp_norm_value, rsp_saturated_flag       rsp_valid / rsp_ready
//   csr      in         csr_norm_mode                            csr_we, no wait
//
// an element passes accept, square and accumulate before req is ready again
// a last element then loads the output register from the done state; in L2 mode the
// square root unit first works out the root in the sqrt state, one root bit per cycle
// a stalled rsp holds the block in its done state; the output register frees req otherwise
// synchronous active-high reset clears the accumulator, the overflow and valid flags and the mode register
module vector_norm_accumulator import vna_pkg::*; #(
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [31:0]          req_element_value,
   input  logic                 req_is_last_element,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [63:0]          rsp_norm_value,
   output logic                 rsp_saturated_flag,
   input  logic                 csr_we,
   input  logic [1:0]           csr_norm_mode
);

   state_type                  state_ff, state_in;
   norm_mode_type              mode_ff;
   logic [ELEMENT_WIDTH-1:0]   mag_ff, mag_in;
   logic                       last_ff;
   logic [2*ELEMENT_WIDTH-1:0] prod_ff;
   logic [ACC_WIDTH-1:0]       acc_ff, acc_in;
   logic                       ovf_ff, ovf_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [63:0]                rsp_norm_ff;
   logic                       rsp_sat_ff;

   logic [ELEMENT_WIDTH-1:0]   elem;
   logic [ACC_WIDTH-1:0]       addend;
   logic [ACC_WIDTH:0]         sum;
   logic                       accept;
   logic                       out_free;
   logic                       load_out;
   logic                       sqrt_start;
   sqrt_status_type            sqrt_status;
   logic [ACC_WIDTH-1:0]       sqrt_root;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_out  = (state_ff == ST_DONE) && out_free;

   // magnitude of the low bits taken as a signed value; the most negative value wraps to 2^(w-1)
   assign elem   = req_element_value[ELEMENT_WIDTH-1:0];
   assign mag_in = elem[ELEMENT_WIDTH-1] ? (~elem + ELEMENT_WIDTH'(1)) : elem;

   assign addend = (mode_ff == MODE_L1) ? ACC_WIDTH'(mag_ff) : ACC_WIDTH'(prod_ff);
   assign sum    = {1'b0, acc_ff} + {1'b0, addend};

   assign sqrt_start = (state_ff == ST_ACC) && last_ff && (mode_ff == MODE_L2);

   vna_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc_in),
      .status   (sqrt_status),
      .root     (sqrt_root)
   );

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (mode_ff == MODE_INF) begin
               if (ACC_WIDTH'(mag_ff) > acc_ff) acc_in = ACC_WIDTH'(mag_ff);
            end else if (sum[ACC_WIDTH]) begin
               acc_in = '1;
               ovf_in = 1'b1;
            end else begin
               acc_in = sum[ACC_WIDTH-1:0];
            end
            if (!last_ff)               state_in = ST_IDLE;
            else if (mode_ff == MODE_L2) state_in = ST_SQRT;
            else                        state_in = ST_DONE;
         end
         ST_SQRT: begin
            if (sqrt_status.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               acc_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_INF;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) mode_ff <= norm_mode_type'(csr_norm_mode);
      end
      if (accept) begin
         mag_ff  <= mag_in;
         last_ff <= req_is_last_element;
      end
      prod_ff <= {{ELEMENT_WIDTH{1'b0}}, mag_ff} * {{ELEMENT_WIDTH{1'b0}}, mag_ff};
      if (load_out) begin
         rsp_norm_ff <= (mode_ff == MODE_L2) ? sqrt_root : acc_ff;
         rsp_sat_ff  <= ovf_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_norm_value     = rsp_norm_ff;
   assign rsp_saturated_flag = rsp_sat_ff;

   a_sqrt_in_state: assert property (@(posedge clock) disable iff (reset)
      sqrt_status.busy |-> (state_ff == ST_SQRT))
      else $error("square root unit busy outside its state");

   a_ovf_saturated: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (acc_ff == {ACC_WIDTH{1'b1}}))
      else $error("overflow flag set without a saturated accumulator");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_DONE))
      else $error("result dropped while output register was full");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MUL))
      else $error("accepted beat did not start the sequencer");

endmodule

FILE: bench/vector_norm_accumulator_tb.sv
// vector_norm_accumulator_tb: self-checking bench for the vector norm accumulator
// streams elements in every norm mode and checks each norm against a built-in predictor
// depends on vna_pkg and vector_norm_accumulator
module vector_norm_accumulator_tb;
   import vna_pkg::*;

   localparam int ITEM_COUNT       = 1950;
   localparam int SETTLE_CYCLES    = 40;    // accept, square, accumulate, load and the square root
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct {
      logic [63:0] norm;
      logic        sat;
   } norm_result_type;

   // predicts the norm of each vector from the accepted element beats
   class norm_tracker_type;
      norm_mode_type   mode;
      logic [63:0]     acc;
      logic            ovf;
      norm_result_type expected_norms[$];
      int              errors;
      int              norms_checked;
      int              saturated_norms;

      function new();
         mode = MODE_INF;
         acc = '0;
         ovf = 1'b0;
         errors = 0;
         norms_checked = 0;
         saturated_norms = 0;
      endfunction

      function void set_mode(norm_mode_type m);
         mode = m;
      endfunction

      function void add_clamped(logic [63:0] addend);
         if (acc > ~64'd0 - addend) begin
            acc = '1;
            ovf = 1'b1;
         end else begin
            acc = acc + addend;
         end
      endfunction

      // bit-by-bit floor root, the root of a 64-bit value fits in 32 bits
      function logic [63:0] floor_root(logic [63:0] x);
         logic [31:0] root;
         logic [31:0] trial;
         int b;
         root = '0;
         for (b = 31; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if ({32'd0, trial} * {32'd0, trial} <= x)
               root = trial;
         end
         return {32'd0, root};
      endfunction

      function void note_element(logic [31:0] value, logic last);
         logic [63:0] mag;
         norm_result_type r;
         mag = value[31] ? (64'h1_0000_0000 - {32'd0, value}) : {32'd0, value};
         case (mode)
            MODE_INF: begin
               if (mag > acc)
                  acc = mag;
            end
            MODE_L1: add_clamped(mag);
            default: add_clamped(mag * mag);
         endcase
         if (last) begin
            r.norm = (mode == MODE_L2) ? floor_root(acc) : acc;
            r.sat = ovf;
            if (ovf)
               saturated_norms++;
            expected_norms.push_back(r);
            acc = '0;
            ovf = 1'b0;
         end
      endfunction

      function void check_norm(logic [63:0] norm, logic sat);
         norm_result_type want;
         if (expected_norms.size() == 0) begin
            $display("%0t: unexpected norm beat, expected none, got norm_value %h saturated_flag %b",
                     $time, norm, sat);
            errors++;
            return;
         end
         want = expected_norms.pop_front();
         norms_checked++;
         if (norm !== want.norm) begin
            $display("%0t: norm_value mismatch, expected %h got %h", $time, want.norm, norm);
            errors++;
         end
         if (sat !== want.sat) begin
            $display("%0t: saturated_flag mismatch, expected %b got %b", $time, want.sat, sat);
            errors++;
         end
      endfunction

      function int pending();
         return expected_norms.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_element_value;
   logic        req_is_last_element;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_norm_value;
   logic        rsp_saturated_flag;
   logic        csr_we;
   logic [1:0]  csr_norm_mode;

   norm_tracker_type norm_calc = new();
   int          elements_sent = 0;
   int          mode_writes = 0;
   int          long_holds = 0;
   bit          no_idle_tx = 1'b0;
   bit          no_idle_rx = 1'b0;
   bit          hold_request = 1'b0;

   vector_norm_accumulator dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_element_value   (req_element_value),
      .req_is_last_element (req_is_last_element),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_norm_value      (rsp_norm_value),
      .rsp_saturated_flag  (rsp_saturated_flag),
      .csr_we              (csr_we),
      .csr_norm_mode       (csr_norm_mode)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [31:0] random_element(bit big);
      logic [31:0] v;
      int r;
      v = $urandom();
      r = $urandom_range(0, 99);
      if (big) begin
         // magnitude at least 2^30 so squares pile up fast
         v[30] = ~v[31];
      end else if (r < 20) begin
         v = {{16{v[31]}}, v[15:0]};
      end else if (r < 35) begin
         case ($urandom_range(0, 5))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h0000_0000;
            3: v = 32'hFFFF_FFFF;
            4: v = 32'h0001_0000;
            default: v = 32'hFFFF_0000;
         endcase
      end
      return v;
   endfunction

   // called right after a rising edge; returns at the edge that accepts the beat
   task automatic push_element(logic [31:0] value, logic last);
      int gap;
      gap = 0;
      if (!no_idle_tx && $urandom_range(0, 99) < 35)
         gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_element_value <= value;
      req_is_last_element <= last;
      do
         @(posedge clock);
      while (!req_ready);
      norm_calc.note_element(value, last);
      elements_sent++;
   endtask

   // hold the sender until every norm is back and the block has gone quiet
   task automatic drain_norms();
      req_valid <= 1'b0;
      while (norm_calc.pending() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(norm_mode_type m);
      drain_norms();
      csr_we <= 1'b1;
      csr_norm_mode <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      norm_calc.set_mode(m);
      mode_writes++;
   endtask

   task automatic send_vector();
      int len;
      int r;
      int i;
      bit big;
      r = $urandom_range(0, 99);
      if (r < 70)
         len = $urandom_range(1, 6);
      else if (r < 93)
         len = $urandom_range(7, 16);
      else
         len = $urandom_range(17, 40);
      big = ($urandom_range(0, 3) == 0);
      for (i = 0; i < len; i++)
         push_element(random_element(big), i == len - 1);
   endtask

   task automatic send_corner_vector();
      push_element(32'hFFFF_FFFF, 1'b0);
      push_element(32'h8000_0000, 1'b0);
      push_element(32'h7FFF_FFFF, 1'b1);
   endtask

   // result side: random stalls plus one long hold-off on request
   initial begin : rsp_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            norm_calc.check_norm(rsp_norm_value, rsp_saturated_flag);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES - 1;
            long_holds++;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (no_idle_rx || $urandom_range(0, 99) < 75) begin
            rsp_ready <= 1'b1;
         end else begin
            stall_left = idle_length() - 1;
            rsp_ready <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no beat moved for %0d cycles, %0d norms still expected",
               $time, WATCHDOG_LIMIT, norm_calc.pending());
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int phase_items;
      int start_count;
      int tail;
      int i;
      norm_mode_type m;
      reset = 1'b1;
      req_valid = 1'b0;
      req_element_value = '0;
      req_is_last_element = 1'b0;
      csr_we = 1'b0;
      csr_norm_mode = MODE_INF;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // corner values in every mode: -1 lsb, most negative, most positive
      write_mode(MODE_INF);
      send_corner_vector();
      write_mode(MODE_L1);
      send_corner_vector();
      write_mode(MODE_L2SQ);
      send_corner_vector();
      write_mode(MODE_L2);
      send_corner_vector();
      push_element(32'h0000_0000, 1'b1);

      // four full-scale squares pass 2^64-1
      write_mode(MODE_L2SQ);
      for (i = 0; i < 5; i++)
         push_element(32'h8000_0000, i == 4);

      // mode switch in the middle of a vector
      write_mode(MODE_L1);
      push_element(32'h0003_0000, 1'b0);
      push_element(32'hFFFE_0000, 1'b0);
      write_mode(MODE_L2);
      push_element(32'h0004_0000, 1'b1);

      start_count = elements_sent;
      phase = 0;
      while (elements_sent - start_count < ITEM_COUNT) begin
         if (phase < 4)
            m = norm_mode_type'(phase);
         else
            m = norm_mode_type'($urandom_range(0, 3));
         write_mode(m);
         no_idle_tx = (phase % 4 == 1) || (phase == 2);
         no_idle_rx = (phase % 4 == 1);
         // block backs up behind a stalled result while the sender keeps pushing
         if (phase == 2)
            hold_request = 1'b1;
         phase_items = $urandom_range(80, 200);
         tail = elements_sent;
         while (elements_sent - tail < phase_items)
            send_vector();
         // sometimes leave a vector open across the mode change
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) push_element(random_element(1'b0), 1'b0);
         phase++;
      end

      drain_norms();
      if (norm_calc.pending() != 0)
         norm_calc.errors++;
      $display("covered %0d elements and %0d norms, %0d of them saturated",
               elements_sent, norm_calc.norms_checked, norm_calc.saturated_norms);
      $display("%0d mode writes over %0d random phases, %0d long result stall(s)",
               mode_writes, phase, long_holds);
      if (norm_calc.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: sim.f
src/vna_pkg.sv
src/vna_isqrt.sv
src/vector_norm_accumulator.sv
bench/vector_norm_accumulator_tb.sv
